>>> hdl/mf5_pkg.sv
// Shared constants, types and register codes for the 5x5 RGB median filter.
// No dependencies; the top level and mf5_median import this package.
`timescale 1ns / 1ps

package mf5_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int HEIGHT_LIMIT = 2048;
    localparam int RADIUS       = 2;
    localparam int SIDE         = 2 * RADIUS + 1;
    localparam int WIN          = SIDE * SIDE;
    localparam int SLOTS        = 3 * RADIUS + 1;
    localparam int BANKS        = SIDE;
    localparam int BANK_DEPTH   = (MAX_WIDTH + BANKS - 1) / BANKS;

    localparam int QUO_W     = $clog2(BANK_DEPTH);
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(HEIGHT_LIMIT);
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int BANK_W    = $clog2(BANKS);
    localparam int LAG_W     = COL_W + 3;
    localparam int CNT_W     = $clog2(WIN + 1);
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;

    localparam int CHANS    = 3;
    localparam int CHAN_W   = 8;
    localparam int PIX_W    = CHANS * CHAN_W;
    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } cfg_reg_t;

    // Channel CH_RED is the most significant byte.
    typedef logic [CHANS-1:0][CHAN_W-1:0] pixel_t;

    typedef struct packed {
        logic valid;
        logic frame_end;
    } med_ctl_t;

endpackage

>>> hdl/median_filter_5x5_rgb.sv
// 5x5 RGB median filter on a raster-order pixel stream, top level.
// Depends on mf5_pkg, mf5_ram (line store banks) and mf5_median (rank select).
`timescale 1ns / 1ps

// The block takes one word per clock and gives one result word per clock in the
// steady state while the output side keeps up. Each result is the per-channel
// median of the 5x5 window around an output pixel, clipped at the frame
// borders, taken from the original input pixels. Results trail the input by two
// rows plus two pixels; after the last pixel of a frame, drain words (tuser
// high) push out the remaining results, and tlast marks the last result of the
// frame. A released result passes the position register (so the line store
// write lands first), the registered memory read, the stage A and B registers
// of the rank select and the output queue. The line store is seven row slots by
// five column banks of RAM, so all 25 window pixels are read in the same cycle;
// no clearing pass is needed after reset. Up to eight results may be owed to the
// output side; when that many are pending, s_axis_tready drops until the output
// side takes one. Width and height must be written only while the block is idle
// (the block itself does not enforce this), and a write restarts the frame.

module median_filter_5x5_rgb (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mf5_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mf5_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [mf5_pkg::PIX_W-1:0]      s_axis_tdata,   // red, green, blue
    input  logic                           s_axis_tuser,   // mode
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [mf5_pkg::PIX_W-1:0]      m_axis_tdata,   // red_out, green_out, blue_out
    output logic                           m_axis_tlast    // frame_end
);

    import mf5_pkg::*;

    // Configuration.
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [COL_W:0]   w_eff;
    logic [ROW_W:0]   h_eff;

    // Input and output positions, with column split as col = 5 * quo + rem.
    logic [COL_W-1:0]  in_col_reg,   in_col_next;
    logic [ROW_W-1:0]  in_row_reg,   in_row_next;
    logic [SLOT_W-1:0] in_slot_reg,  in_slot_next;
    logic [BANK_W-1:0] in_rem_reg,   in_rem_next;
    logic [QUO_W-1:0]  in_quo_reg,   in_quo_next;
    logic              in_done_reg,  in_done_next;
    logic [LAG_W-1:0]  lag_reg,      lag_next;
    logic [COL_W-1:0]  out_col_reg,  out_col_next;
    logic [ROW_W-1:0]  out_row_reg,  out_row_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [BANK_W-1:0] out_rem_reg,  out_rem_next;
    logic [QUO_W-1:0]  out_quo_reg,  out_quo_next;
    logic [FIFO_AW:0]  used_reg,     used_next;

    logic             accept;
    logic             take;
    logic             in_last;
    logic             out_last;
    logic             done_after;
    logic [LAG_W-1:0] lag_after;
    logic [LAG_W-1:0] lag_thr;
    logic             emit;
    pixel_t           in_pix;

    // Window address stage.
    logic              p1_valid_reg;
    logic              p1_last_reg;
    logic [COL_W-1:0]  p1_col_reg;
    logic [ROW_W-1:0]  p1_row_reg;
    logic [SLOT_W-1:0] p1_slot_reg;
    logic [BANK_W-1:0] p1_rem_reg;
    logic [QUO_W-1:0]  p1_quo_reg;

    logic signed [COL_W+1:0]  col_pos  [SIDE];
    logic signed [BANK_W+1:0] rem_pos  [SIDE];
    logic signed [ROW_W+1:0]  row_pos  [SIDE];
    logic signed [SLOT_W+1:0] slot_pos [SIDE];
    logic [SIDE-1:0]          col_ok;
    logic [SIDE-1:0]          row_ok;
    logic [BANK_W-1:0]        col_bank [SIDE];
    logic [QUO_W-1:0]         col_quo  [SIDE];
    logic [SLOT_W-1:0]        row_slot [SIDE];
    logic [QUO_W-1:0]         rd_addr  [BANKS];

    // Memory data stage.
    med_ctl_t          p2_ctl_reg;
    logic [SIDE-1:0]   p2_col_ok_reg;
    logic [SIDE-1:0]   p2_row_ok_reg;
    logic [BANK_W-1:0] p2_bank_reg [SIDE];
    logic [SLOT_W-1:0] p2_slot_reg [SIDE];
    logic [PIX_W-1:0]  ram_q [SLOTS][BANKS];
    pixel_t            win_pix [WIN];
    logic [WIN-1:0]    win_mask;

    med_ctl_t med_ctl;
    pixel_t   med_pix;

    // Output queue.
    pixel_t           fifo_pix_reg  [FIFO_DEPTH];
    logic             fifo_last_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   fifo_cnt_reg;
    logic             push;
    logic             pop;

    // ------------------------------------------------------------------
    // Configuration registers and their effective (clamped) values.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = (COL_W+1)'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = (COL_W+1)'(MAX_WIDTH);
        end
        else
        begin
            w_eff = (COL_W+1)'(width_reg);
        end

        if (height_reg == '0)
        begin
            h_eff = (ROW_W+1)'(1);
        end
        else if (32'(height_reg) > HEIGHT_LIMIT)
        begin
            h_eff = (ROW_W+1)'(HEIGHT_LIMIT);
        end
        else
        begin
            h_eff = (ROW_W+1)'(height_reg);
        end
    end

    // ------------------------------------------------------------------
    // Input side: line store write and the decision to release a result.
    // lag counts input pixels stored ahead of the next output pixel.
    // ------------------------------------------------------------------
    assign s_axis_tready = used_reg < (FIFO_AW+1)'(FIFO_DEPTH);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign take          = accept && !s_axis_tuser && !in_done_reg;

    assign in_pix[CH_RED]   = s_axis_tdata[CHAN_W-1:0];
    assign in_pix[CH_GREEN] = s_axis_tdata[2*CHAN_W-1:CHAN_W];
    assign in_pix[CH_BLUE]  = s_axis_tdata[3*CHAN_W-1:2*CHAN_W];

    assign in_last  = ((COL_W+1)'(in_col_reg) == w_eff - (COL_W+1)'(1)) &&
                      ((ROW_W+1)'(in_row_reg) == h_eff - (ROW_W+1)'(1));
    assign out_last = ((COL_W+1)'(out_col_reg) == w_eff - (COL_W+1)'(1)) &&
                      ((ROW_W+1)'(out_row_reg) == h_eff - (ROW_W+1)'(1));

    assign done_after = in_done_reg || (take && in_last);
    assign lag_after  = lag_reg + LAG_W'(take);
    assign lag_thr    = LAG_W'(w_eff) * LAG_W'(RADIUS) + LAG_W'(RADIUS + 1);
    assign emit       = accept && (done_after || (lag_after >= lag_thr));

    assign pop = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_slot_next  = in_slot_reg;
        in_rem_next   = in_rem_reg;
        in_quo_next   = in_quo_reg;
        in_done_next  = in_done_reg;
        lag_next      = lag_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        out_rem_next  = out_rem_reg;
        out_quo_next  = out_quo_reg;
        used_next     = used_reg + (FIFO_AW+1)'(emit) - (FIFO_AW+1)'(pop);

        if (cfg_we)
        begin
            in_col_next   = '0;
            in_row_next   = '0;
            in_slot_next  = '0;
            in_rem_next   = '0;
            in_quo_next   = '0;
            in_done_next  = 1'b0;
            lag_next      = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_slot_next = '0;
            out_rem_next  = '0;
            out_quo_next  = '0;
        end
        else if (accept)
        begin
            if (take)
            begin
                if ((COL_W+1)'(in_col_reg) == w_eff - (COL_W+1)'(1))
                begin
                    in_col_next  = '0;
                    in_rem_next  = '0;
                    in_quo_next  = '0;
                    in_row_next  = in_row_reg + ROW_W'(1);
                    in_slot_next = (in_slot_reg == SLOT_W'(SLOTS - 1)) ? '0
                                   : in_slot_reg + SLOT_W'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + COL_W'(1);
                    if (in_rem_reg == BANK_W'(BANKS - 1))
                    begin
                        in_rem_next = '0;
                        in_quo_next = in_quo_reg + QUO_W'(1);
                    end
                    else
                    begin
                        in_rem_next = in_rem_reg + BANK_W'(1);
                    end
                end
            end
            in_done_next = done_after;
            lag_next     = lag_after;

            if (emit)
            begin
                if (out_last)
                begin
                    // Last result of the frame: the next pixel starts a new frame.
                    in_col_next   = '0;
                    in_row_next   = '0;
                    in_slot_next  = '0;
                    in_rem_next   = '0;
                    in_quo_next   = '0;
                    in_done_next  = 1'b0;
                    lag_next      = '0;
                    out_col_next  = '0;
                    out_row_next  = '0;
                    out_slot_next = '0;
                    out_rem_next  = '0;
                    out_quo_next  = '0;
                end
                else
                begin
                    lag_next = lag_after - LAG_W'(1);
                    if ((COL_W+1)'(out_col_reg) == w_eff - (COL_W+1)'(1))
                    begin
                        out_col_next  = '0;
                        out_rem_next  = '0;
                        out_quo_next  = '0;
                        out_row_next  = out_row_reg + ROW_W'(1);
                        out_slot_next = (out_slot_reg == SLOT_W'(SLOTS - 1)) ? '0
                                        : out_slot_reg + SLOT_W'(1);
                    end
                    else
                    begin
                        out_col_next = out_col_reg + COL_W'(1);
                        if (out_rem_reg == BANK_W'(BANKS - 1))
                        begin
                            out_rem_next = '0;
                            out_quo_next = out_quo_reg + QUO_W'(1);
                        end
                        else
                        begin
                            out_rem_next = out_rem_reg + BANK_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            in_rem_reg   <= '0;
            in_quo_reg   <= '0;
            in_done_reg  <= 1'b0;
            lag_reg      <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            out_rem_reg  <= '0;
            out_quo_reg  <= '0;
            used_reg     <= '0;
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_slot_reg  <= in_slot_next;
            in_rem_reg   <= in_rem_next;
            in_quo_reg   <= in_quo_next;
            in_done_reg  <= in_done_next;
            lag_reg      <= lag_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_slot_reg <= out_slot_next;
            out_rem_reg  <= out_rem_next;
            out_quo_reg  <= out_quo_next;
            used_reg     <= used_next;
            p1_valid_reg <= emit;
        end
    end

    // The released output position is registered, so that the read below
    // sees the pixel written by the same word.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            p1_last_reg <= out_last;
            p1_col_reg  <= out_col_reg;
            p1_row_reg  <= out_row_reg;
            p1_slot_reg <= out_slot_reg;
            p1_rem_reg  <= out_rem_reg;
            p1_quo_reg  <= out_quo_reg;
        end
    end

    // ------------------------------------------------------------------
    // Window addressing. The five window columns fall in five different
    // banks, and the five window rows in five different slots.
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int b = 0; b < BANKS; b++)
        begin
            rd_addr[b] = '0;
        end

        for (int d = 0; d < SIDE; d++)
        begin
            col_pos[d] = $signed({2'b00, p1_col_reg}) + $signed((COL_W+2)'(d - RADIUS));
            col_ok[d]  = (col_pos[d] >= 0) && (col_pos[d] < $signed({1'b0, w_eff}));
            rem_pos[d] = $signed({2'b00, p1_rem_reg}) + $signed((BANK_W+2)'(d - RADIUS));
            if (rem_pos[d] < 0)
            begin
                col_bank[d] = BANK_W'(rem_pos[d] + $signed((BANK_W+2)'(BANKS)));
                col_quo[d]  = p1_quo_reg - QUO_W'(1);
            end
            else if (rem_pos[d] >= $signed((BANK_W+2)'(BANKS)))
            begin
                col_bank[d] = BANK_W'(rem_pos[d] - $signed((BANK_W+2)'(BANKS)));
                col_quo[d]  = p1_quo_reg + QUO_W'(1);
            end
            else
            begin
                col_bank[d] = BANK_W'(rem_pos[d]);
                col_quo[d]  = p1_quo_reg;
            end
            rd_addr[col_bank[d]] = col_quo[d];

            row_pos[d]  = $signed({2'b00, p1_row_reg}) + $signed((ROW_W+2)'(d - RADIUS));
            row_ok[d]   = (row_pos[d] >= 0) && (row_pos[d] < $signed({1'b0, h_eff}));
            slot_pos[d] = $signed({2'b00, p1_slot_reg}) + $signed((SLOT_W+2)'(d - RADIUS));
            if (slot_pos[d] < 0)
            begin
                row_slot[d] = SLOT_W'(slot_pos[d] + $signed((SLOT_W+2)'(SLOTS)));
            end
            else if (slot_pos[d] >= $signed((SLOT_W+2)'(SLOTS)))
            begin
                row_slot[d] = SLOT_W'(slot_pos[d] - $signed((SLOT_W+2)'(SLOTS)));
            end
            else
            begin
                row_slot[d] = SLOT_W'(slot_pos[d]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_ctl_reg <= '0;
        end
        else
        begin
            p2_ctl_reg.valid     <= p1_valid_reg;
            p2_ctl_reg.frame_end <= p1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p2_col_ok_reg <= col_ok;
        p2_row_ok_reg <= row_ok;
        p2_bank_reg   <= col_bank;
        p2_slot_reg   <= row_slot;
    end

    // ------------------------------------------------------------------
    // Line store: one RAM per row slot and column bank. The pixel at
    // (row, col) lives in slot row mod 7, bank col mod 5, entry col / 5.
    // ------------------------------------------------------------------
    for (genvar s = 0; s < SLOTS; s++)
    begin : g_slot
        for (genvar b = 0; b < BANKS; b++)
        begin : g_bank
            mf5_ram #(
                .WIDTH (PIX_W),
                .DEPTH (BANK_DEPTH)
            ) u_ram (
                .clk   (clk),
                .we    (take && (in_slot_reg == SLOT_W'(s)) && (in_rem_reg == BANK_W'(b))),
                .waddr (in_quo_reg),
                .wdata (in_pix),
                .raddr (rd_addr[b]),
                .rdata (ram_q[s][b])
            );
        end
    end

    // Gather the 25 window pixels; clipped positions are masked out.
    always_comb
    begin
        for (int m = 0; m < SIDE; m++)
        begin
            for (int d = 0; d < SIDE; d++)
            begin
                win_mask[m * SIDE + d] = p2_row_ok_reg[m] && p2_col_ok_reg[d];
                win_pix[m * SIDE + d]  = win_mask[m * SIDE + d]
                                         ? pixel_t'(ram_q[p2_slot_reg[m]][p2_bank_reg[d]])
                                         : '0;
            end
        end
    end

    mf5_median u_median (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (p2_ctl_reg),
        .in_pix  (win_pix),
        .in_mask (win_mask),
        .out_ctl (med_ctl),
        .out_pix (med_pix)
    );

    // ------------------------------------------------------------------
    // Output queue. used_reg reserves a place for every released result,
    // so the queue cannot overflow and the pipeline never stalls.
    // ------------------------------------------------------------------
    assign push = med_ctl.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_pix_reg[wr_ptr_reg]  <= med_pix;
            fifo_last_reg[wr_ptr_reg] <= med_ctl.frame_end;
        end
    end

    assign m_axis_tvalid = fifo_cnt_reg != '0;
    assign m_axis_tdata  = {fifo_pix_reg[rd_ptr_reg][CH_BLUE],
                            fifo_pix_reg[rd_ptr_reg][CH_GREEN],
                            fifo_pix_reg[rd_ptr_reg][CH_RED]};
    assign m_axis_tlast  = fifo_last_reg[rd_ptr_reg];

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_fifo_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ((fifo_cnt_reg < (FIFO_AW+1)'(FIFO_DEPTH)) || pop))
        else $error("output queue written while full");

    a_credit_covers_queue: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg >= fifo_cnt_reg)
        else $error("reserved result count below queue occupancy");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && out_last && !cfg_we) |=>
            ((lag_reg == '0) && !in_done_reg && (out_col_reg == '0) && (in_col_reg == '0)))
        else $error("positions not cleared after the last result of a frame");

endmodule

>>> hdl/mf5_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies. A read at the address being written returns the old data.
`timescale 1ns / 1ps

module mf5_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/mf5_median.sv
// Three-stage rank-select median over a masked window, one window per cycle.
// Depends on mf5_pkg for the window size, pixel type and control struct.
`timescale 1ns / 1ps

module mf5_median (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mf5_pkg::med_ctl_t       in_ctl,
    input  mf5_pkg::pixel_t         in_pix [mf5_pkg::WIN],
    input  logic [mf5_pkg::WIN-1:0] in_mask,
    output mf5_pkg::med_ctl_t       out_ctl,
    output mf5_pkg::pixel_t         out_pix
);

    import mf5_pkg::*;

    logic [WIN-1:0]   lt_next [CHANS][WIN];
    logic [WIN-1:0]   le_next [CHANS][WIN];
    logic [WIN-1:0]   lt_reg  [CHANS][WIN];
    logic [WIN-1:0]   le_reg  [CHANS][WIN];
    pixel_t           pix_a_reg [WIN];
    logic [WIN-1:0]   mask_a_reg;
    med_ctl_t         ctl_a_reg;

    logic [CNT_W-1:0] ltc_next [CHANS][WIN];
    logic [CNT_W-1:0] lec_next [CHANS][WIN];
    logic [CNT_W-1:0] ltc_reg  [CHANS][WIN];
    logic [CNT_W-1:0] lec_reg  [CHANS][WIN];
    logic [CNT_W-1:0] k_next;
    logic [CNT_W-1:0] k_reg;
    pixel_t           pix_b_reg [WIN];
    logic [WIN-1:0]   mask_b_reg;
    med_ctl_t         ctl_b_reg;

    // Stage A: every value against every other value, per channel.
    always_comb
    begin
        for (int c = 0; c < CHANS; c++)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                for (int j = 0; j < WIN; j++)
                begin
                    lt_next[c][i][j] = in_mask[j] && (in_pix[j][c] < in_pix[i][c]);
                    le_next[c][i][j] = in_mask[j] && (in_pix[j][c] <= in_pix[i][c]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
        end
        else
        begin
            ctl_a_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        lt_reg     <= lt_next;
        le_reg     <= le_next;
        pix_a_reg  <= in_pix;
        mask_a_reg <= in_mask;
    end

    // Stage B: ranks. A value owns the sorted positions [lt, le).
    always_comb
    begin
        for (int c = 0; c < CHANS; c++)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                ltc_next[c][i] = CNT_W'($countones(lt_reg[c][i]));
                lec_next[c][i] = CNT_W'($countones(le_reg[c][i]));
            end
        end
        k_next = CNT_W'($countones(mask_a_reg)) >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_b_reg <= '0;
        end
        else
        begin
            ctl_b_reg <= ctl_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ltc_reg    <= ltc_next;
        lec_reg    <= lec_next;
        k_reg      <= k_next;
        pix_b_reg  <= pix_a_reg;
        mask_b_reg <= mask_a_reg;
    end

    // Select: all entries that hold position k carry the same value.
    always_comb
    begin
        out_pix = '0;
        for (int c = 0; c < CHANS; c++)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                if (mask_b_reg[i] && (ltc_reg[c][i] <= k_reg) && (k_reg < lec_reg[c][i]))
                begin
                    out_pix[c] = out_pix[c] | pix_b_reg[i][c];
                end
            end
        end
        out_ctl = ctl_b_reg;
    end

endmodule
